### hdl/bbcf_pkg.sv
// ----------------------------------------------------------------------------
// bbcf_pkg: shared types and constants for the band center finder
// Payload structs, config register map, count widths and queue sizing.
// ----------------------------------------------------------------------------
package bbcf_pkg;

  // Default frame limits
  localparam int MAX_COLUMNS_DEF = 512;
  localparam int MAX_ROWS_DEF    = 512;

  // Field widths
  localparam int PIXEL_W = 8;
  localparam int COUNT_W = 10;
  localparam int BAND_W  = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  // Saturation ceiling of a line count
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Config register reset values
  localparam logic               AXIS_MODE_RST      = 1'b1;
  localparam logic [COUNT_W-1:0] LINE_THRESHOLD_RST = COUNT_W'(50);
  localparam logic [PIXEL_W-1:0] WHITE_VALUE_RST    = PIXEL_W'(255);

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_VALUE    = 2'd2;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Input request
  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               row_end;
    logic               frame_end;
  } px_t;

  // Result request
  typedef struct packed {
    logic [BAND_W-1:0] band_center;
    logic [BAND_W-1:0] band_first;
    logic [BAND_W-1:0] band_last;
    logic              band_found;
  } band_t;

  // Live configuration
  typedef struct packed {
    logic               axis_mode;
    logic [COUNT_W-1:0] line_threshold;
    logic [PIXEL_W-1:0] white_value;
  } cfg_t;

  // Width of one queue entry for the given frame limits
  function automatic int entry_width(input int cols, input int rows);
    return $clog2(cols) + $clog2(rows) + 5;
  endfunction

endpackage

### hdl/bbcf_queue.sv
// ----------------------------------------------------------------------------
// bbcf_queue: small FIFO between front and back
// Register-based queue; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module bbcf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/bbcf_front.sv
// ----------------------------------------------------------------------------
// bbcf_front: pixel intake and classification
// Tracks raster position and row counts, tags each pixel for the back end.
// ----------------------------------------------------------------------------
module bbcf_front #(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 512,
  localparam int ENTRY_W    = bbcf_pkg::entry_width(MAX_COLUMNS, MAX_ROWS)
) (
  input  logic               clk,
  input  logic               rst,
  input  bbcf_pkg::cfg_t     cfg,
  input  logic               px_valid,
  output logic               px_ready,
  input  bbcf_pkg::px_t      px,
  input  logic               q_full,
  output logic               q_push,
  output logic [ENTRY_W-1:0] q_data
);

  import bbcf_pkg::*;

  localparam int COL_AW = $clog2(MAX_COLUMNS);
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_IW = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_IW = $clog2(MAX_ROWS + 1);

  typedef struct packed {
    logic              col_op;
    logic [COL_AW-1:0] col_addr;
    logic              white;
    logic              first_row;
    logic              row_qual;
    logic [ROW_AW-1:0] row_idx;
    logic              frame_end;
  } entry_t;

  logic [COL_IW-1:0]  col_idx;
  logic [ROW_IW-1:0]  row_idx;
  logic [COUNT_W-1:0] run_count;
  logic               first_row;

  logic               accept;
  logic               white;
  logic               line_end;
  logic               col_in;
  logic               row_in;
  logic [COUNT_W:0]   run_sum;
  logic [COUNT_W-1:0] run_sat;
  entry_t             entry;

  assign px_ready = !q_full;
  assign accept   = px_valid && px_ready;

  // Classify the current pixel
  always_comb begin
    white    = (px.pixel == cfg.white_value);
    line_end = px.row_end || px.frame_end;
    col_in   = (col_idx < COL_IW'(MAX_COLUMNS));
    row_in   = (row_idx < ROW_IW'(MAX_ROWS));
    run_sum  = {1'b0, run_count} + (COUNT_W + 1)'(white);
    run_sat  = run_sum[COUNT_W] ? COUNT_MAX : run_sum[COUNT_W-1:0];

    entry.col_op    = cfg.axis_mode && col_in;
    entry.col_addr  = COL_AW'(col_idx);
    entry.white     = white;
    entry.first_row = first_row;
    entry.row_qual  = !cfg.axis_mode && line_end && row_in &&
                      (run_sat >= cfg.line_threshold);
    entry.row_idx   = ROW_AW'(row_idx);
    entry.frame_end = px.frame_end;
  end

  assign q_push = accept;
  assign q_data = entry;

  // Raster position and row count
  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx   <= '0;
      row_idx   <= '0;
      run_count <= '0;
      first_row <= 1'b1;
    end else if (accept) begin
      if (px.frame_end) begin
        col_idx   <= '0;
        row_idx   <= '0;
        run_count <= '0;
        first_row <= 1'b1;
      end else if (line_end) begin
        col_idx   <= '0;
        run_count <= '0;
        first_row <= 1'b0;
        if (row_in) begin
          row_idx <= row_idx + 1'b1;
        end
      end else if (cfg.axis_mode) begin
        if (col_in) begin
          col_idx <= col_idx + 1'b1;
        end
      end else begin
        run_count <= run_sat;
      end
    end
  end

endmodule

### hdl/bbcf_back.sv
// ----------------------------------------------------------------------------
// bbcf_back: column count update, band tracking and result output
// Two steps: column memory read, then update, qualify and emit.
// ----------------------------------------------------------------------------
module bbcf_back #(
  parameter int MAX_COLUMNS = 512,
  parameter int MAX_ROWS    = 512,
  localparam int ENTRY_W    = bbcf_pkg::entry_width(MAX_COLUMNS, MAX_ROWS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  bbcf_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  logic [ENTRY_W-1:0]   q_head,
  output logic                 q_pop,
  output logic                 band_valid,
  input  logic                 band_ready,
  output bbcf_pkg::band_t      band
);

  import bbcf_pkg::*;

  localparam int COL_AW = $clog2(MAX_COLUMNS);
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int LINE_W = (COL_AW > ROW_AW) ? COL_AW : ROW_AW;

  typedef struct packed {
    logic              col_op;
    logic [COL_AW-1:0] col_addr;
    logic              white;
    logic              first_row;
    logic              row_qual;
    logic [ROW_AW-1:0] row_idx;
    logic              frame_end;
  } entry_t;

  logic [COUNT_W-1:0] col_mem [MAX_COLUMNS];

  entry_t             head;
  entry_t             s2;
  logic               s2_valid;
  logic               s2_done;
  logic               load;
  logic [COUNT_W-1:0] rd_q;
  logic               fwd_hit;
  logic [COUNT_W-1:0] fwd_data;

  logic               wr_en;
  logic [COL_AW-1:0]  wr_addr;
  logic [COUNT_W-1:0] wr_data;

  logic               found;
  logic [LINE_W-1:0]  bstart;
  logic [LINE_W-1:0]  bstop;
  logic               found_next;
  logic [LINE_W-1:0]  bstart_next;
  logic [LINE_W-1:0]  bstop_next;

  logic [COUNT_W-1:0] cur;
  logic [COUNT_W:0]   sum;
  logic [COUNT_W-1:0] cnt;
  logic               qual;
  logic [LINE_W-1:0]  qual_idx;
  logic [LINE_W:0]    mid_sum;
  band_t              result;

  assign head = entry_t'(q_head);

  // Step control: step two holds a frame end until the output slot frees
  assign s2_done = s2_valid && (!s2.frame_end || !band_valid || band_ready);
  assign load    = !q_empty && (!s2_valid || s2_done);
  assign q_pop   = load;

  // Column count update with saturation
  always_comb begin
    cur     = fwd_hit ? fwd_data : rd_q;
    sum     = {1'b0, cur} + (COUNT_W + 1)'(s2.white);
    if (s2.first_row) begin
      cnt = COUNT_W'(s2.white);
    end else begin
      cnt = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
    end
    wr_en   = s2_done && s2.col_op;
    wr_addr = s2.col_addr;
    wr_data = cnt;
  end

  // Line qualification and band extent
  always_comb begin
    qual     = (s2.col_op && (cnt >= cfg.line_threshold)) || s2.row_qual;
    qual_idx = s2.col_op ? LINE_W'(s2.col_addr) : LINE_W'(s2.row_idx);
    found_next  = found;
    bstart_next = bstart;
    bstop_next  = bstop;
    if (qual) begin
      if (!found) begin
        found_next  = 1'b1;
        bstart_next = qual_idx;
        bstop_next  = qual_idx;
      end else begin
        if (qual_idx < bstart) begin
          bstart_next = qual_idx;
        end
        if (qual_idx > bstop) begin
          bstop_next = qual_idx;
        end
      end
    end
  end

  // Frame result
  always_comb begin
    mid_sum = {1'b0, bstart_next} + {1'b0, bstop_next};
    if (found_next) begin
      result.band_center = BAND_W'(mid_sum[LINE_W:1]);
      result.band_first  = BAND_W'(bstart_next);
      result.band_last   = BAND_W'(bstop_next);
      result.band_found  = 1'b1;
    end else begin
      result.band_center = '0;
      result.band_first  = '0;
      result.band_last   = '0;
      result.band_found  = 1'b0;
    end
  end

  // Column count memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      col_mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, with bypass of the write in the same cycle
  always_ff @(posedge clk) begin
    if (load) begin
      rd_q     <= col_mem[head.col_addr];
      fwd_hit  <= wr_en && (wr_addr == head.col_addr);
      fwd_data <= wr_data;
      s2       <= head;
    end
  end

  // Step two valid and band state
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      found    <= 1'b0;
      bstart   <= '0;
      bstop    <= '0;
    end else begin
      if (load) begin
        s2_valid <= 1'b1;
      end else if (s2_done) begin
        s2_valid <= 1'b0;
      end
      if (s2_done) begin
        if (s2.frame_end) begin
          found  <= 1'b0;
          bstart <= '0;
          bstop  <= '0;
        end else begin
          found  <= found_next;
          bstart <= bstart_next;
          bstop  <= bstop_next;
        end
      end
    end
  end

  // Output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      band_valid <= 1'b0;
    end else if (s2_done && s2.frame_end) begin
      band_valid <= 1'b1;
    end else if (band_ready) begin
      band_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_done && s2.frame_end) begin
      band <= result;
    end
  end

  // Checks
  a_band_order: assert property (@(posedge clk) disable iff (rst)
    found |-> (bstart <= bstop))
    else $error("band start above band stop");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !s2_done) |=> (s2_valid && $stable(rd_q) && $stable(fwd_hit)))
    else $error("column read data changed while step two stalled");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (band_valid && !band.band_found) |->
      (band.band_center == '0 && band.band_first == '0 && band.band_last == '0))
    else $error("nonzero result without a qualifying line");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

endmodule

### hdl/binary_band_center_finder_top.sv
// ----------------------------------------------------------------------------
// binary_band_center_finder_top: band center finder over a binary image
// Throughput: one pixel per cycle while the queue is not full (a held result
//   backs up into it); the column count memory is read and written once per
//   cycle with a write-to-read bypass. Path: an accepted frame end pixel goes
//   through the queue and the column read register, then into the output register.
// Reset: synchronous rst clears control state and loads the config registers
//   with their reset values; the column count memory is not cleared, the first row of a frame rewrites it.
// ----------------------------------------------------------------------------
module binary_band_center_finder_top #(
  parameter int MAX_COLUMNS = bbcf_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = bbcf_pkg::MAX_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bbcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbcf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 px_valid,
  output logic                                 px_ready,
  input  bbcf_pkg::px_t                        px,
  output logic                                 band_valid,
  input  logic                                 band_ready,
  output bbcf_pkg::band_t                      band
);

  import bbcf_pkg::*;

  localparam int ENTRY_W = entry_width(MAX_COLUMNS, MAX_ROWS);

  cfg_t               cfg;
  logic               q_push;
  logic [ENTRY_W-1:0] q_data;
  logic               q_pop;
  logic [ENTRY_W-1:0] q_head;
  logic               q_full;
  logic               q_empty;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_mode      <= AXIS_MODE_RST;
      cfg.line_threshold <= LINE_THRESHOLD_RST;
      cfg.white_value    <= WHITE_VALUE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AXIS_MODE:      cfg.axis_mode      <= cfg_data[0];
        REG_LINE_THRESHOLD: cfg.line_threshold <= COUNT_W'(cfg_data);
        REG_WHITE_VALUE:    cfg.white_value    <= PIXEL_W'(cfg_data);
        default: ;
      endcase
    end
  end

  bbcf_front #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .px_valid(px_valid),
    .px_ready(px_ready),
    .px      (px),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_data)
  );

  bbcf_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_data),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  bbcf_back #(
    .MAX_COLUMNS(MAX_COLUMNS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .band_valid(band_valid),
    .band_ready(band_ready),
    .band      (band)
  );

endmodule

### tb/sv/binary_band_center_finder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_band_center_finder_top_test: self-checking bench for the band finder
// Streams binary frames in raster order with random gaps and result stalls.
// A scoreboard tracks the row and column counts and checks each band report.
// ----------------------------------------------------------------------------
module binary_band_center_finder_top_test;
  import bbcf_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 500;
  localparam int RANDOM_FRAMES = 20;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  px_valid;
  logic                  px_ready;
  px_t                   px;
  logic                  band_valid;
  logic                  band_ready;
  band_t                 band;

  // handshakes between the sender and the receiver process
  bit calm;
  bit hold_req;
  bit hold_active;
  int stall_cycles;
  int sent_items;

  binary_band_center_finder_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .px_valid   (px_valid),
    .px_ready   (px_ready),
    .px         (px),
    .band_valid (band_valid),
    .band_ready (band_ready),
    .band       (band)
  );

  // Tracks line counts and band limits; holds the band reports still due
  class band_scoreboard;
    logic               axis_col;
    logic [COUNT_W-1:0] thresh;
    logic [PIXEL_W-1:0] white_val;
    logic [COUNT_W-1:0] col_cnt [MAX_COLUMNS_DEF];
    logic [COUNT_W-1:0] run_cnt;
    logic [9:0]         col_pos;
    logic [9:0]         row_pos;
    bit                 first_row;
    bit                 found;
    logic [BAND_W-1:0]  lo;
    logic [BAND_W-1:0]  hi;
    int                 cols_written;
    band_t              pending_bands[$];
    int                 errors;

    function new();
      axis_col     = AXIS_MODE_RST;
      thresh       = LINE_THRESHOLD_RST;
      white_val    = WHITE_VALUE_RST;
      cols_written = 0;
      errors       = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      run_cnt   = '0;
      col_pos   = '0;
      row_pos   = '0;
      first_row = 1'b1;
      found     = 1'b0;
      lo        = '0;
      hi        = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_AXIS_MODE:      axis_col = d[0];
        REG_LINE_THRESHOLD: thresh = d[COUNT_W-1:0];
        REG_WHITE_VALUE:    white_val = d[PIXEL_W-1:0];
        default: ;
      endcase
    endfunction

    function void mark(logic [BAND_W-1:0] idx);
      if (!found) begin
        lo    = idx;
        hi    = idx;
        found = 1'b1;
      end else begin
        if (idx < lo) lo = idx;
        if (idx > hi) hi = idx;
      end
    endfunction

    // True in column mode past the first row when the next column is in range and never written since reset
    function bit next_col_unwritten();
      return axis_col && !first_row && (col_pos + 1 < MAX_COLUMNS_DEF) &&
             (col_pos + 1 >= cols_written);
    endfunction

    // Advance the count state by one accepted pixel request
    function void take_pixel(px_t p);
      logic [COUNT_W:0]  sum;
      logic [BAND_W:0]   mid;
      logic              w;
      logic              lend;
      band_t             want;
      w    = (p.pixel == white_val);
      lend = p.row_end | p.frame_end;
      if (axis_col) begin
        if (col_pos < MAX_COLUMNS_DEF) begin
          if (first_row) sum = (COUNT_W+1)'(w);
          else sum = {1'b0, col_cnt[col_pos]} + (COUNT_W+1)'(w);
          if (sum > COUNT_MAX) sum = {1'b0, COUNT_MAX};
          col_cnt[col_pos] = sum[COUNT_W-1:0];
          if (sum >= thresh) mark(col_pos[BAND_W-1:0]);
          col_pos = col_pos + 1'b1;
          if (int'(col_pos) > cols_written) cols_written = int'(col_pos);
        end
      end else begin
        sum = {1'b0, run_cnt} + (COUNT_W+1)'(w);
        if (sum > COUNT_MAX) sum = {1'b0, COUNT_MAX};
        run_cnt = sum[COUNT_W-1:0];
        if (lend && row_pos < MAX_ROWS_DEF && run_cnt >= thresh) mark(row_pos[BAND_W-1:0]);
      end
      if (lend) begin
        run_cnt   = '0;
        col_pos   = '0;
        first_row = 1'b0;
        if (row_pos < MAX_ROWS_DEF) row_pos = row_pos + 1'b1;
      end
      if (p.frame_end) begin
        // lo and hi stay zero when nothing qualified
        mid              = {1'b0, lo} + {1'b0, hi};
        want.band_center = mid[BAND_W:1];
        want.band_first  = lo;
        want.band_last   = hi;
        want.band_found  = found;
        pending_bands.push_back(want);
        clear_frame();
      end
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_band(band_t got);
      band_t want;
      if (pending_bands.size() == 0) begin
        $display("%0t ns: band report with none pending, actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_bands.pop_front();
      compare("band_center", want.band_center, got.band_center);
      compare("band_first", want.band_first, got.band_first);
      compare("band_last", want.band_last, got.band_last);
      compare("band_found", want.band_found, got.band_found);
    endfunction
  endclass

  band_scoreboard sb;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result monitor and stall counter
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else begin
      if (band_valid && band_ready) sb.check_band(band);
      if ((px_valid && px_ready) || (band_valid && band_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // Watchdog
  initial begin
    @(negedge rst);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("** binary_band_center_finder_top: FAILED **");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request, none when calm
  initial begin
    band_ready = 1'b0;
    @(negedge rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_active = 1'b1;
        band_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else if (calm) begin
        band_ready <= 1'b1;
        @(posedge clk);
      end else begin
        band_ready <= 1'b1;
        repeat ($urandom_range(0, 7) == 0 ? 120 : $urandom_range(1, 20)) @(posedge clk);
        band_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // Offer one pixel request and hold it until accepted
  task automatic push_pixel(input logic [PIXEL_W-1:0] v, input logic rend, input logic fend);
    px_valid <= 1'b1;
    px       <= {v, rend, fend};
    @(posedge clk);
    while (!px_ready) @(posedge clk);
    sb.take_pixel({v, rend, fend});
    sent_items++;
  endtask

  task automatic pause_sender();
    px_valid <= 1'b0;
    repeat ($urandom_range(1, 19)) @(posedge clk);
  endtask

  // Drain all pending reports, then let the pipeline empty
  task automatic settle();
    px_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bands.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic set_config(input logic mode, input logic [COUNT_W-1:0] thr,
                            input logic [PIXEL_W-1:0] wv);
    write_reg(REG_AXIS_MODE, CFG_DATA_W'(mode));
    write_reg(REG_LINE_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_WHITE_VALUE, CFG_DATA_W'(wv));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One frame: first row of first_len pixels, later rows ragged by up to spread.
  // A row is cut short rather than step onto a column never written.
  task automatic run_frame(input int rows, input int first_len, input int spread,
                           input int white_pct, input bit gaps);
    int           len;
    bit           stop;
    bit           last_row;
    logic [7:0]   v;
    logic         rend;
    logic         fend;
    for (int r = 0; r < rows; r++) begin
      len      = (r == 0 || spread == 0) ? first_len : $urandom_range(1, first_len + spread);
      last_row = (r == rows - 1);
      for (int c = 0; c < len; c++) begin
        stop = (c == len - 1) || sb.next_col_unwritten();
        v    = ($urandom_range(1, 100) <= white_pct) ? sb.white_val : 8'($urandom_range(0, 255));
        rend = stop;
        fend = 1'b0;
        if (stop && last_row) begin
          fend = 1'b1;
          rend = 1'($urandom_range(0, 1));
        end
        push_pixel(v, rend, fend);
        if (gaps && $urandom_range(0, 11) == 0) pause_sender();
        if (stop) break;
      end
    end
  endtask

  task automatic random_settings();
    logic [COUNT_W-1:0] thr;
    logic [PIXEL_W-1:0] wv;
    case ($urandom_range(0, 19))
      0, 1:    thr = '0;
      2:       thr = COUNT_MAX;
      3:       thr = 10'd512;
      default: thr = 10'($urandom_range(1, 9));
    endcase
    case ($urandom_range(0, 7))
      0, 1:    wv = 8'hFF;
      2:       wv = 8'h00;
      default: wv = 8'($urandom_range(0, 255));
    endcase
    set_config(1'($urandom_range(0, 1)), thr, wv);
  endtask

  // Stimulus
  initial begin
    int base;
    int frames;
    sb        = new();
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    px_valid  = 1'b0;
    px        = '0;
    calm      = 1'b0;
    hold_req  = 1'b0;
    hold_active = 1'b0;
    sent_items  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: a lone white pixel stays below the default threshold
    push_pixel(8'hFF, 1'b0, 1'b1);
    settle();

    // column mode, two rows of three: band over columns 0..2
    set_config(1'b1, 10'd1, 8'hFF);
    push_pixel(8'hFF, 1'b0, 1'b0);
    push_pixel(8'h00, 1'b0, 1'b0);
    push_pixel(8'hFF, 1'b1, 1'b0);
    push_pixel(8'h00, 1'b0, 1'b0);
    push_pixel(8'h7F, 1'b0, 1'b0);
    push_pixel(8'hFF, 1'b1, 1'b1);
    settle();

    // row mode with zero threshold: every row qualifies, white is zero
    set_config(1'b0, 10'd0, 8'h00);
    push_pixel(8'hFF, 1'b0, 1'b0);
    push_pixel(8'h00, 1'b1, 1'b0);
    push_pixel(8'hAB, 1'b0, 1'b1);
    settle();

    // axis change in the middle of a frame
    set_config(1'b0, 10'd1, 8'hFF);
    push_pixel(8'hFF, 1'b0, 1'b0);
    push_pixel(8'h00, 1'b1, 1'b0);
    settle();
    set_config(1'b1, 10'd1, 8'hFF);
    push_pixel(8'h00, 1'b0, 1'b0);
    push_pixel(8'hFF, 1'b0, 1'b0);
    push_pixel(8'h00, 1'b0, 1'b1);
    settle();

    // ragged rows: later rows longer than the first reuse old column counts
    set_config(1'b1, 10'd2, 8'hFF);
    push_pixel(8'hFF, 1'b1, 1'b0);
    push_pixel(8'hFF, 1'b0, 1'b0);
    push_pixel(8'hFF, 1'b0, 1'b0);
    push_pixel(8'hFF, 1'b1, 1'b0);
    push_pixel(8'hFF, 1'b0, 1'b0);
    push_pixel(8'hFF, 1'b0, 1'b0);
    push_pixel(8'hFF, 1'b0, 1'b1);
    settle();

    // long result hold-off: single pixel frames back up into the input
    hold_req = 1'b1;
    wait (hold_active);
    for (int i = 0; i < 40; i++) begin
      push_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end
    settle();

    // wide frame: columns past the limit are ignored
    set_config(1'b1, 10'd1, 8'h5A);
    run_frame(1, 514, 0, 60, 1'b0);
    settle();

    // random frames, mostly small, settings changed between frames
    base   = sent_items;
    frames = 0;
    while (sent_items - base < RANDOM_ITEMS || frames < RANDOM_FRAMES) begin
      calm = (sent_items - base) > (RANDOM_ITEMS * 85 / 100);
      if (!calm && $urandom_range(0, 2) == 0) begin
        settle();
        random_settings();
      end
      run_frame($urandom_range(1, 8), $urandom_range(1, 12),
                $urandom_range(0, 1) ? 0 : $urandom_range(0, 4),
                $urandom_range(0, 100), !calm && $urandom_range(0, 1));
      frames++;
    end

    // wind down
    calm = 1'b1;
    settle();
    if (sb.errors == 0) begin
      $display("** binary_band_center_finder_top: PASSED **");
    end else begin
      $display("** binary_band_center_finder_top: FAILED **");
    end
    $finish;
  end

endmodule
